>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the min/max aggregator.
// A checking build gets assertions; a build with SYNTHESIS defined gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MMRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define MMRA_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define MMRA_ASSERT(lbl, prop)
`define MMRA_ASSERT_NR(lbl, prop)
`endif
`endif

>>> rtl/mmra_pkg.sv
// ----------------------------------------------------------------------------
// mmra_pkg
// Types and codes shared by the min/max request aggregator.
// ----------------------------------------------------------------------------
`default_nettype none
package mmra_pkg;
  localparam int NUM_RESOURCES_DEF = 16;
  localparam int NUM_HANDLES_DEF   = 16;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_REMALL = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [1:0] CFG_PRESENT = 2'd0;
  localparam logic [1:0] CFG_POLICY  = 2'd1;

  typedef enum logic [1:0] {
    ACT_APPLY   = 2'd0,
    ACT_RESET   = 2'd1,
    ACT_UNKNOWN = 2'd2,
    ACT_NONE    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    K_SET     = 2'd0,
    K_REMOVE  = 2'd1,
    K_REMALL  = 2'd2,
    K_UNKNOWN = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] handle;
    logic       hok;
    logic [3:0] resource;
  } cmd_t;

  typedef struct packed {
    logic [3:0] resource;
    act_e       action;
    logic       last;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
endpackage
`default_nettype wire

>>> rtl/mmra_ram.sv
// ----------------------------------------------------------------------------
// mmra_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mmra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/mmra_queue.sv
// ----------------------------------------------------------------------------
// mmra_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mmra_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  `MMRA_ASSERT(a_cnt_range, cnt_q <= CW'(DEPTH))
  `MMRA_ASSERT(a_no_pop_empty, pop_i |-> !empty_o)
  `MMRA_ASSERT(a_no_push_full, push_i |-> !full_o)
endmodule
`default_nettype wire

>>> rtl/mmra_front.sv
// ----------------------------------------------------------------------------
// mmra_front
// Takes items from the command port, classifies them and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module mmra_front
  import mmra_pkg::*;
#(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_HANDLES   = NUM_HANDLES_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  wire logic                  accept_i,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [3:0]            client_handle_i,
  input  wire logic [3:0]            resource_index_i,
  input  wire logic [31:0]           request_value_i,
  input  wire logic [15:0]           present_i,
  output logic                       push_o,
  output cmd_t                       cmd_o,
  output logic      [VALUE_BITS-1:0] value_o
);
  logic        known;
  logic [63:0] v64;

  always_comb begin
    v64   = {{32{request_value_i[31]}}, request_value_i};
    known = ({3'b0, resource_index_i} < 7'(NUM_RESOURCES)) && present_i[resource_index_i];
    cmd_o.handle   = client_handle_i;
    cmd_o.resource = resource_index_i;
    cmd_o.hok      = ({3'b0, client_handle_i} < 7'(NUM_HANDLES));
    if (opcode_i == OP_REMALL) begin
      cmd_o.kind = K_REMALL;
    end else if (!known) begin
      cmd_o.kind = K_UNKNOWN;
    end else if (opcode_i == OP_SET) begin
      cmd_o.kind = K_SET;
    end else begin
      cmd_o.kind = K_REMOVE;
    end
    // opcode three is dropped here: no command, no result
    push_o = accept_i && (opcode_i == OP_SET || opcode_i == OP_REMOVE ||
                          opcode_i == OP_REMALL);
  end

  assign value_o = v64[VALUE_BITS-1:0];
endmodule
`default_nettype wire

>>> rtl/mmra_back.sv
// ----------------------------------------------------------------------------
// mmra_back
// Executes queued commands: updates the request table and resolves resources.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mmra_back
  import mmra_pkg::*;
#(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_HANDLES   = NUM_HANDLES_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  cmd_t                       q_cmd_i,
  input  wire logic [VALUE_BITS-1:0] q_value_i,
  output logic                       q_pop_o,
  input  wire logic [15:0]           present_i,
  input  wire logic [15:0]           policy_i,
  output logic                       out_valid_o,
  output res_t                       out_res_o,
  output logic      [31:0]           out_winner_o
);
  localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam int AW = RW + HW;
  localparam int CW = $clog2(NUM_HANDLES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RES  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [NUM_HANDLES-1:0]  act_q [NUM_RESOURCES];
  logic [NUM_HANDLES-1:0]  act_d [NUM_RESOURCES];
  logic [RW-1:0]           r_q, r_d, si_q, si_d;
  logic [HW-1:0]           h_q, h_d;
  logic [CW-1:0]           hc_q, hc_d;
  logic [4:0]              cnt_q, cnt_d;
  logic                    remall_q, remall_d, last_q, last_d, min_q, min_d;
  logic                    pv_q, pv_d, pl_q, pl_d, have_q, have_d;
  logic [VALUE_BITS-1:0]   best_q, best_d;
  logic                    ov_q, ov_d;
  res_t                    ores_q, ores_d;
  logic [VALUE_BITS-1:0]   owin_q, owin_d;
  logic [63:0]             w64;

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [VALUE_BITS-1:0]   rdata;

  logic [RW-1:0]           rr;
  logic [HW-1:0]           hh, hsel;
  logic [NUM_RESOURCES-1:0] col;
  logic                    later, lst, kn, better;
  logic [NUM_HANDLES-1:0]  row;

  mmra_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(2 ** AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(q_value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    r_d      = r_q;
    si_d     = si_q;
    h_d      = h_q;
    hc_d     = hc_q;
    cnt_d    = cnt_q;
    remall_d = remall_q;
    last_d   = last_q;
    min_d    = min_q;
    pv_d     = 1'b0;
    pl_d     = 1'b0;
    have_d   = have_q;
    best_d   = best_q;
    ov_d     = 1'b0;
    ores_d   = ores_q;
    owin_d   = owin_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    rr       = RW'(q_cmd_i.resource);
    hh       = HW'(q_cmd_i.handle);
    waddr    = {rr, hh};
    raddr    = {r_q, hc_q[HW-1:0]};
    hsel     = (state_q == S_IDLE) ? hh : h_q;
    for (int k = 0; k < NUM_RESOURCES; k++) begin
      col[k] = act_q[k][hsel];
    end
    later = 1'b0;
    for (int k = 0; k < NUM_RESOURCES; k++) begin
      if (RW'(k) > si_q && col[k]) begin
        later = 1'b1;
      end
    end
    lst    = !later || (cnt_q == 5'd15);
    kn     = (7'(si_q) < 7'd16) && present_i[4'(si_q)];
    row    = act_q[si_q] & ~(NUM_HANDLES'(1) << h_q);
    better = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            K_UNKNOWN: begin
              ov_d   = 1'b1;
              ores_d = '{resource: q_cmd_i.resource, action: ACT_UNKNOWN, last: 1'b1};
              owin_d = '0;
            end
            K_REMALL: begin
              if (!q_cmd_i.hok || col == '0) begin
                ov_d   = 1'b1;
                ores_d = '{resource: 4'd0, action: ACT_NONE, last: 1'b1};
                owin_d = '0;
              end else begin
                h_d      = hh;
                si_d     = '0;
                cnt_d    = '0;
                remall_d = 1'b1;
                state_d  = S_SCAN;
              end
            end
            default: begin
              if (q_cmd_i.hok) begin
                act_d[rr][hh] = (q_cmd_i.kind == K_SET);
                we            = (q_cmd_i.kind == K_SET);
              end
              if (act_d[rr] == '0) begin
                ov_d   = 1'b1;
                ores_d = '{resource: q_cmd_i.resource, action: ACT_RESET, last: 1'b1};
                owin_d = '0;
              end else begin
                r_d      = rr;
                remall_d = 1'b0;
                last_d   = 1'b1;
                min_d    = policy_i[q_cmd_i.resource];
                hc_d     = '0;
                have_d   = 1'b0;
                state_d  = S_RES;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (col[si_q]) begin
          act_d[si_q][h_q] = 1'b0;
          if (kn && row != '0) begin
            r_d     = si_q;
            last_d  = lst;
            min_d   = policy_i[4'(si_q)];
            hc_d    = '0;
            have_d  = 1'b0;
            state_d = S_RES;
          end else begin
            ov_d   = 1'b1;
            ores_d = '{resource: 4'(si_q), action: kn ? ACT_RESET : ACT_UNKNOWN, last: lst};
            owin_d = '0;
            cnt_d  = cnt_q + 1'b1;
            if (lst) begin
              // past the result cap the rest of the column is freed silently
              for (int k = 0; k < NUM_RESOURCES; k++) begin
                act_d[k][h_q] = 1'b0;
              end
              state_d = S_IDLE;
            end else begin
              si_d = si_q + 1'b1;
            end
          end
        end else begin
          si_d = si_q + 1'b1;
        end
      end
      S_RES: begin
        // issue one handle read per cycle; compare when data returns
        if (hc_q < CW'(NUM_HANDLES)) begin
          re   = 1'b1;
          pv_d = act_q[r_q][hc_q[HW-1:0]];
          pl_d = (hc_q == CW'(NUM_HANDLES - 1));
          hc_d = hc_q + 1'b1;
        end
        if (pv_q) begin
          better = min_q ? ($signed(rdata) < $signed(best_q))
                         : ($signed(rdata) > $signed(best_q));
          if (!have_q || better) begin
            best_d = rdata;
          end
          have_d = 1'b1;
        end
        if (pl_q) begin
          ov_d   = 1'b1;
          ores_d = '{resource: 4'(r_q), action: ACT_APPLY, last: last_q};
          owin_d = best_d;
          if (!remall_q) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (last_q) begin
              for (int k = 0; k < NUM_RESOURCES; k++) begin
                act_d[k][h_q] = 1'b0;
              end
              state_d = S_IDLE;
            end else begin
              si_d    = si_q + 1'b1;
              state_d = S_SCAN;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int k = 0; k < NUM_RESOURCES; k++) begin
        act_q[k] <= '0;
      end
      si_q     <= '0;
      h_q      <= '0;
      r_q      <= '0;
      hc_q     <= '0;
      cnt_q    <= '0;
      remall_q <= 1'b0;
      last_q   <= 1'b0;
      min_q    <= 1'b0;
      pv_q     <= 1'b0;
      pl_q     <= 1'b0;
      have_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      si_q     <= si_d;
      h_q      <= h_d;
      r_q      <= r_d;
      hc_q     <= hc_d;
      cnt_q    <= cnt_d;
      remall_q <= remall_d;
      last_q   <= last_d;
      min_q    <= min_d;
      pv_q     <= pv_d;
      pl_q     <= pl_d;
      have_q   <= have_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    ores_q <= ores_d;
    owin_q <= owin_d;
  end

  assign w64          = 64'(owin_q);
  assign out_valid_o  = ov_q;
  assign out_res_o    = ores_q;
  assign out_winner_o = w64[31:0];

  `MMRA_ASSERT(a_pop_idle, q_pop_o |-> state_q == S_IDLE)
  `MMRA_ASSERT(a_last_idle, (ov_q && ores_q.last) |-> state_q == S_IDLE)
  `MMRA_ASSERT(a_hc_range, hc_q <= CW'(NUM_HANDLES))
endmodule
`default_nettype wire

>>> rtl/min_max_request_aggregator.sv
// ----------------------------------------------------------------------------
// min_max_request_aggregator
// Per resource min/max aggregation of client requests.
// ----------------------------------------------------------------------------
// A set or remove reaches its result through one table read per handle,
// then the compare of the last value; unknown resources and resources left
// without requests answer without any table read. A remove all walks the
// resources one per cycle and stops on each one it frees that still has
// requests, to resolve it. A two entry command queue sits in front of the
// engine, so busy rises only when that queue is full. Results come as
// one cycle strobes on result_valid_o and cannot be held off; last_result_o
// marks the final result of an item.
`default_nettype none
module min_max_request_aggregator
  import mmra_pkg::*;
#(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int NUM_HANDLES   = NUM_HANDLES_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  client_handle_i,
  input  wire logic [3:0]  resource_index_i,
  input  wire logic [31:0] request_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             result_valid_o,
  output logic      [3:0]  resolved_resource_o,
  output logic      [1:0]  action_o,
  output logic      [31:0] winner_value_o,
  output logic             last_result_o
);
  localparam int QW = CMD_W + VALUE_BITS;

  logic [15:0]           present_q, policy_q;
  logic                  push, pop, q_empty, q_full;
  cmd_t                  f_cmd;
  logic [VALUE_BITS-1:0] f_value;
  logic [QW-1:0]         q_rdata;
  res_t                  res;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 16'hFFFF;
      policy_q  <= 16'h0000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRESENT: present_q <= cfg_data_i;
        CFG_POLICY:  policy_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mmra_front #(
    .NUM_RESOURCES(NUM_RESOURCES),
    .NUM_HANDLES  (NUM_HANDLES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_front (
    .accept_i        (start && !q_full),
    .opcode_i        (opcode_i),
    .client_handle_i (client_handle_i),
    .resource_index_i(resource_index_i),
    .request_value_i (request_value_i),
    .present_i       (present_q),
    .push_o          (push),
    .cmd_o           (f_cmd),
    .value_o         (f_value)
  );

  mmra_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({f_cmd, f_value}),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  mmra_back #(
    .NUM_RESOURCES(NUM_RESOURCES),
    .NUM_HANDLES  (NUM_HANDLES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (cmd_t'(q_rdata[QW-1:VALUE_BITS])),
    .q_value_i   (q_rdata[VALUE_BITS-1:0]),
    .q_pop_o     (pop),
    .present_i   (present_q),
    .policy_i    (policy_q),
    .out_valid_o (result_valid_o),
    .out_res_o   (res),
    .out_winner_o(winner_value_o)
  );

  assign resolved_resource_o = res.resource;
  assign action_o            = res.action;
  assign last_result_o       = res.last;
endmodule
`default_nettype wire

>>> tb/sv/mmra_checker.sv
// ----------------------------------------------------------------------------
// mmra_checker
// Watches the command, configuration and result channels of the aggregator,
// keeps its own copy of the request table and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module mmra_checker
  import mmra_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  client_handle_i,
  input  wire logic [3:0]  resource_index_i,
  input  wire logic [31:0] request_value_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        result_valid_o,
  input  wire logic [3:0]  resolved_resource_o,
  input  wire logic [1:0]  action_o,
  input  wire logic [31:0] winner_value_o,
  input  wire logic        last_result_o,
  output int               err_cnt_o,
  output int               pending_o,
  output int               items_o,
  output int               results_o
);

  typedef struct {
    logic [3:0]  resource;
    act_e        action;
    logic [31:0] value;
    logic        last;
  } outcome_t;

  logic signed [31:0] level_tbl [16][16];
  logic [15:0]        holders [16];
  logic [15:0]        present_mask;
  logic [15:0]        min_mask;
  outcome_t           outcome_q [$];

  assign pending_o = outcome_q.size();

  function automatic void push_outcome(logic [3:0] r, act_e a, logic [31:0] v);
    outcome_t o;
    o.resource = r;
    o.action   = a;
    o.value    = v;
    o.last     = 1'b0;
    outcome_q.push_back(o);
  endfunction

  function automatic void resolve_resource(logic [3:0] r);
    logic signed [31:0] best;
    logic               have;
    best = '0;
    have = 1'b0;
    if (holders[r] == '0) begin
      push_outcome(r, ACT_RESET, '0);
      return;
    end
    for (int h = 0; h < 16; h++) begin
      if (holders[r][h]) begin
        if (!have) best = level_tbl[r][h];
        else if (min_mask[r] ? (level_tbl[r][h] < best) : (level_tbl[r][h] > best))
          best = level_tbl[r][h];
        have = 1'b1;
      end
    end
    push_outcome(r, ACT_APPLY, best);
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [3:0] h, logic [3:0] r,
                                       logic [31:0] v);
    int n;
    n = 0;
    if (op == OP_SET || op == OP_REMOVE) begin
      if (!present_mask[r]) begin
        push_outcome(r, ACT_UNKNOWN, '0);
      end else begin
        if (op == OP_SET) begin
          level_tbl[r][h] = v;
          holders[r][h]   = 1'b1;
        end else begin
          holders[r][h] = 1'b0;
        end
        resolve_resource(r);
      end
      n = 1;
    end else if (op == OP_REMALL) begin
      for (int i = 0; i < 16; i++) begin
        if (holders[i][h]) begin
          holders[i][h] = 1'b0;
          if (present_mask[i]) resolve_resource(4'(i));
          else push_outcome(4'(i), ACT_UNKNOWN, '0);
          n++;
        end
      end
      if (n == 0) begin
        push_outcome('0, ACT_NONE, '0);
        n = 1;
      end
    end
    // opcode three is dropped by the block
    if (n > 0) outcome_q[outcome_q.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t o;
    if (!rst_ni) begin
      for (int r = 0; r < 16; r++) holders[r] = '0;
      present_mask = 16'hFFFF;
      min_mask     = '0;
      outcome_q.delete();
      err_cnt_o = 0;
      items_o   = 0;
      results_o = 0;
    end else begin
      if (result_valid_o) begin
        results_o++;
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result, resource", 32'(resolved_resource_o), '0);
        end else begin
          o = outcome_q.pop_front();
          if (resolved_resource_o !== o.resource)
            report_mismatch("resolved_resource", 32'(resolved_resource_o), 32'(o.resource));
          if (action_o !== o.action)
            report_mismatch("action", 32'(action_o), 32'(o.action));
          if (winner_value_o !== o.value)
            report_mismatch("winner_value", winner_value_o, o.value);
          if (last_result_o !== o.last)
            report_mismatch("last_result", 32'(last_result_o), 32'(o.last));
        end
      end
      if (start && !busy) begin
        items_o++;
        predict_item(opcode_i, client_handle_i, resource_index_i, request_value_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_PRESENT) present_mask = cfg_data_i;
        else if (cfg_index_i == CFG_POLICY) min_mask = cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_min_max_request_aggregator.sv
// ----------------------------------------------------------------------------
// tb_min_max_request_aggregator
// Drives directed and random set / remove / remove-all items through several
// presence and policy settings, with random idle bursts; the checker predicts.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_min_max_request_aggregator;
  import mmra_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  opcode_i;
  logic [3:0]  client_handle_i;
  logic [3:0]  resource_index_i;
  logic [31:0] request_value_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        result_valid_o;
  logic [3:0]  resolved_resource_o;
  logic [1:0]  action_o;
  logic [31:0] winner_value_o;
  logic        last_result_o;
  int          err_cnt, pending, item_cnt, result_cnt;
  int          stall_cnt = 0;
  logic        idle_en;

  min_max_request_aggregator u_dut (.*);

  mmra_checker u_chk (
    .*,
    .err_cnt_o (err_cnt),
    .pending_o (pending),
    .items_o   (item_cnt),
    .results_o (result_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] h, logic [3:0] r, logic [31:0] v);
    start            <= 1'b1;
    opcode_i         <= op;
    client_handle_i  <= h;
    resource_index_i <= r;
    request_value_i  <= v;
    do @(posedge clk_i); while (busy);
    if (idle_en && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    logic [1:0]  op;
    logic [3:0]  r;
    logic [31:0] v;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 55) ? OP_SET : (pick < 75) ? OP_REMOVE : (pick < 93) ? OP_REMALL : OP_IGNORE;
      // crowd a few resources so many handles stack on each
      r = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'($urandom_range(0, 3)) - 32'd2;
        default: v = $urandom;
      endcase
      send_item(op, 4'($urandom_range(0, 15)), r, v);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    opcode_i         = '0;
    client_handle_i  = '0;
    resource_index_i = '0;
    request_value_i  = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    idle_en          = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_PRESENT, 16'hFFFF);
    write_reg(CFG_POLICY, 16'h0000);
    send_item(OP_SET, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send_item(OP_SET, 4'd15, 4'd0, 32'h8000_0000);
    send_item(OP_REMOVE, 4'd0, 4'd0, '0);
    send_item(OP_REMOVE, 4'd15, 4'd0, '0);       // resource left empty
    send_item(OP_REMOVE, 4'd3, 4'd15, 32'hFFFF_FFFF);
    send_item(OP_SET, 4'd5, 4'd15, 32'hFFFF_FFFF);
    send_item(OP_SET, 4'd6, 4'd15, '0);
    send_item(OP_REMALL, 4'd5, 4'd9, '0);
    send_item(OP_REMALL, 4'd5, 4'd0, '0);        // frees nothing
    send_item(OP_IGNORE, 4'd1, 4'd1, 32'h1234_5678);  // dropped opcode
    send_item(OP_SET, 4'd9, 4'd3, 32'd5);
    send_item(OP_SET, 4'd9, 4'd7, 32'hFFFF_FFFB);
    send_item(OP_SET, 4'd9, 4'd12, 32'd123);
    send_item(OP_SET, 4'd2, 4'd3, 32'h8000_0000);
    drain();

    // minimum policy everywhere, resource 7 dropped while still held
    write_reg(CFG_POLICY, 16'hFFFF);
    write_reg(CFG_PRESENT, 16'hFF7F);
    send_item(OP_SET, 4'd4, 4'd3, 32'h7FFF_FFFF);
    send_item(OP_REMALL, 4'd9, 4'd0, '0);
    send_item(OP_SET, 4'd1, 4'd7, 32'd1);
    send_item(OP_REMOVE, 4'd1, 4'd7, '0);
    random_items(60);
    drain();

    write_reg(CFG_PRESENT, 16'($urandom) | 16'h000F);
    write_reg(CFG_POLICY, 16'($urandom));
    random_items(70);
    drain();

    write_reg(CFG_PRESENT, 16'h0000);
    random_items(30);
    drain();

    write_reg(CFG_PRESENT, 16'hFFFF);
    write_reg(CFG_POLICY, 16'h5A5A);
    random_items(60);
    idle_en = 1'b0;
    random_items(80);
    drain();

    $display("covered %0d items and %0d results over five presence/policy settings",
             item_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
